### hdl/fdd_pkg.sv
// Shared types and codes for the finite-difference derivative block.
`timescale 1ns / 1ps

package fdd_pkg;

    // mode register codes
    localparam logic [1:0] MODE_FORWARD  = 2'd0;
    localparam logic [1:0] MODE_BACKWARD = 2'd1;
    localparam logic [1:0] MODE_CENTERED = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_ZERO_STEP = 2'd1;
    localparam logic [1:0] STAT_SINGLE    = 2'd2;

    // position within the current series
    localparam logic [1:0] POS_NONE = 2'd0;
    localparam logic [1:0] POS_ONE  = 2'd1;
    localparam logic [1:0] POS_MORE = 2'd2;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // quotient bits produced by the serial divider
    localparam int QUO_BITS = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ABS,
        S_CHECK,
        S_DIV,
        S_FIX,
        S_SEL,
        S_MEAN,
        S_OUT1,
        S_OUT2
    } fdd_state_t;

endpackage

### hdl/finite_difference_derivative_top.sv
// Finite-difference derivative dy/dx of a Q16.16 sample stream, bit-serial divider.
`timescale 1ns / 1ps
//
// Usage: s_* carries one (x, y) sample per request, both signed Q16.16, with s_tlast
//   marking the final sample of a series. m_* carries the slope in m_tdata, the
//   status in m_tuser (ok, zero x step saturated, single-sample series) and the
//   series end in m_tlast. cfg_* writes the 2-bit mode (forward, backward, centered;
//   3 = centered); the user writes it only while the block is idle (not enforced).
// Steps: difference, magnitude and range check, then a restoring divider that
//   makes one quotient bit per cycle, then sign fix, select and output. A
//   centered interior sample adds a mean step before output, and a second result
//   an output step of its own. A zero x step or an out-of-range quotient skips
//   the divider and sign fix.
// Flow: one sample at a time; s_tready returns once the last result sits in the
//   output register. The first sample of a longer series gives no result and
//   leaves s_tready high.
// Reset: aresetn (synchronous, active low) clears the previous sample, slope,
//   series position and output valid, and sets mode to centered.
// Stall: while m_tready is low the output register holds; a second result waits
//   until the first is taken; the next sample is accepted, but its result waits too.

module finite_difference_derivative_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input samples
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] x_value, [63:32] y_value
    input  logic        s_tlast,   // series_end
    // derivative results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] slope
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast,   // last
    // mode register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);
    import fdd_pkg::*;

    fdd_state_t state_reg, state_next;

    logic [1:0]         mode_reg, mode_next;
    logic [31:0]        prev_x_reg, prev_x_next;
    logic [31:0]        prev_y_reg, prev_y_next;
    logic [31:0]        prev_slope_reg, prev_slope_next;
    logic               prev_flag_reg, prev_flag_next;
    logic [1:0]         pos_reg, pos_next;

    // per-sample working registers
    logic [1:0]         item_pos_reg, item_pos_next;
    logic               item_end_reg, item_end_next;
    logic               item_cent_reg, item_cent_next;
    logic signed [32:0] dx_reg, dx_next;
    logic signed [32:0] dy_reg, dy_next;
    logic [32:0]        den_reg, den_next;       // |dx|
    logic [32:0]        num_reg, num_next;       // |dy|
    logic               neg_reg, neg_next;
    logic [32:0]        rem_reg, rem_next;
    logic [31:0]        dvd_reg, dvd_next;       // dividend bits still to shift in
    logic [31:0]        quo_reg, quo_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [31:0]        s_reg, s_next;
    logic               f_reg, f_next;
    logic signed [32:0] sum_reg, sum_next;

    // pending first result; the optional second one is (s, f, last)
    logic [31:0]        r1_slope_reg, r1_slope_next;
    logic [1:0]         r1_status_reg, r1_status_next;
    logic               r1_last_reg, r1_last_next;
    logic               two_reg, two_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [31:0]        m_data_reg, m_data_next;
    logic [1:0]         m_user_reg, m_user_next;
    logic               m_last_reg, m_last_next;

    logic               s_accept;
    logic               out_free;
    logic [31:0]        x_in, y_in;
    logic [33:0]        shifted;
    logic               fits;
    logic [32:0]        mean_adj;
    logic               cent_now;

    assign x_in      = s_tdata[31:0];
    assign y_in      = s_tdata[63:32];
    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign cent_now  = !(mode_reg == MODE_FORWARD || mode_reg == MODE_BACKWARD);

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign shifted  = {rem_reg, dvd_reg[31]};
    assign fits     = shifted >= {1'b0, den_reg};
    // truncate toward zero: bump odd negative sums before the halving
    assign mean_adj = sum_reg + {32'd0, sum_reg[32] & sum_reg[0]};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_CENTERED;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_slope_reg <= '0;
            prev_flag_reg  <= 1'b0;
            pos_reg        <= POS_NONE;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            prev_slope_reg <= prev_slope_next;
            prev_flag_reg  <= prev_flag_next;
            pos_reg        <= pos_next;
            m_valid_reg    <= m_valid_next;
        end
        item_pos_reg  <= item_pos_next;
        item_end_reg  <= item_end_next;
        item_cent_reg <= item_cent_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        den_reg       <= den_next;
        num_reg       <= num_next;
        neg_reg       <= neg_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
        s_reg         <= s_next;
        f_reg         <= f_next;
        sum_reg       <= sum_next;
        r1_slope_reg  <= r1_slope_next;
        r1_status_reg <= r1_status_next;
        r1_last_reg   <= r1_last_next;
        two_reg       <= two_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
        m_last_reg    <= m_last_next;
    end

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        prev_slope_next = prev_slope_reg;
        prev_flag_next  = prev_flag_reg;
        pos_next        = pos_reg;
        item_pos_next   = item_pos_reg;
        item_end_next   = item_end_reg;
        item_cent_next  = item_cent_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        den_next        = den_reg;
        num_next        = num_reg;
        neg_next        = neg_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        s_next          = s_reg;
        f_next          = f_reg;
        sum_next        = sum_reg;
        r1_slope_next   = r1_slope_reg;
        r1_status_next  = r1_status_reg;
        r1_last_next    = r1_last_reg;
        two_next        = two_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        m_last_next     = m_last_reg;

        if (cfg_valid && cfg_ready) begin
            mode_next = cfg_data;
        end

        // result taken downstream
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    item_pos_next  = pos_reg;
                    item_end_next  = s_tlast;
                    item_cent_next = cent_now;
                    dx_next = $signed({x_in[31], x_in}) - $signed({prev_x_reg[31], prev_x_reg});
                    dy_next = $signed({y_in[31], y_in}) - $signed({prev_y_reg[31], prev_y_reg});
                    prev_x_next = x_in;
                    prev_y_next = y_in;
                    if (s_tlast) begin
                        pos_next = POS_NONE;
                    end else if (pos_reg == POS_NONE) begin
                        pos_next = POS_ONE;
                    end else begin
                        pos_next = POS_MORE;
                    end
                    if (pos_reg == POS_NONE) begin
                        // single-sample series, or silent first sample
                        r1_slope_next  = '0;
                        r1_status_next = STAT_SINGLE;
                        r1_last_next   = 1'b1;
                        two_next       = 1'b0;
                        state_next     = s_tlast ? S_OUT1 : S_IDLE;
                    end else begin
                        state_next = S_ABS;
                    end
                end
            end
            S_ABS: begin
                den_next   = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
                num_next   = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
                neg_next   = dx_reg[32] ^ dy_reg[32];
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (den_reg == '0) begin
                    // zero x step: saturate by the sign of dy, zero when dy is zero too
                    f_next = 1'b1;
                    if (num_reg == '0) begin
                        s_next = '0;
                    end else begin
                        s_next = dy_reg[32] ? SAT_MIN : SAT_MAX;
                    end
                    state_next = S_SEL;
                end else if ({16'd0, num_reg[32:16]} >= den_reg) begin
                    // quotient reaches 2^32: out of range either way
                    f_next     = 1'b0;
                    s_next     = neg_reg ? SAT_MIN : SAT_MAX;
                    state_next = S_SEL;
                end else begin
                    rem_next   = {16'd0, num_reg[32:16]};
                    dvd_next   = {num_reg[15:0], 16'd0};
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                rem_next = fits ? 33'(shifted - {1'b0, den_reg}) : shifted[32:0];
                dvd_next = {dvd_reg[30:0], 1'b0};
                quo_next = {quo_reg[30:0], fits};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(QUO_BITS - 1)) begin
                    state_next = S_FIX;
                end
            end
            S_FIX: begin
                f_next = 1'b0;
                if (!neg_reg) begin
                    s_next = quo_reg[31] ? SAT_MAX : quo_reg;
                end else if (quo_reg[31] && (quo_reg[30:0] != '0)) begin
                    s_next = SAT_MIN;
                end else begin
                    s_next = -quo_reg;
                end
                state_next = S_SEL;
            end
            S_SEL: begin
                r1_slope_next  = s_reg;
                r1_status_next = f_reg ? STAT_ZERO_STEP : STAT_OK;
                if (!item_cent_reg) begin
                    r1_last_next = item_end_reg;
                    two_next     = 1'b0;
                    state_next   = S_OUT1;
                end else if (item_pos_reg == POS_ONE) begin
                    r1_last_next = 1'b0;
                    two_next     = item_end_reg;
                    state_next   = S_OUT1;
                end else begin
                    sum_next   = $signed({prev_slope_reg[31], prev_slope_reg})
                               + $signed({s_reg[31], s_reg});
                    state_next = S_MEAN;
                end
            end
            S_MEAN: begin
                r1_slope_next  = mean_adj[32:1];
                r1_status_next = (f_reg || prev_flag_reg) ? STAT_ZERO_STEP : STAT_OK;
                r1_last_next   = 1'b0;
                two_next       = item_end_reg;
                state_next     = S_OUT1;
            end
            S_OUT1: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = r1_slope_reg;
                    m_user_next  = r1_status_reg;
                    m_last_next  = r1_last_reg;
                    if (item_pos_reg != POS_NONE) begin
                        prev_slope_next = s_reg;
                        prev_flag_next  = f_reg;
                    end
                    state_next = two_reg ? S_OUT2 : S_IDLE;
                end
            end
            S_OUT2: begin
                // centered end point: the one-sided slope
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = s_reg;
                    m_user_next  = f_reg ? STAT_ZERO_STEP : STAT_OK;
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // single-sample result is always a last zero
    a_single_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg == STAT_SINGLE) |-> (m_last_reg && m_data_reg == '0))
        else $error("single-sample result malformed");

    // divider runs exactly QUO_BITS steps
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && cnt_reg == 5'(QUO_BITS - 1)) |=> (state_reg == S_FIX))
        else $error("divider step count wrong");

    // a second result only follows the first
    a_out2_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT2) |-> ($past(state_reg) == S_OUT1 || $past(state_reg) == S_OUT2))
        else $error("second result without first");

    // first sample of a longer series produces nothing
    a_first_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && pos_reg == POS_NONE && !s_tlast) |=> (state_reg == S_IDLE))
        else $error("first sample started work");

endmodule
